// File: sv/assert_macros.svh
// assertion macros used by the packetizer core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition holds in the cycle after the trigger
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/ctip_pkg.sv
// types and codes of the control in transfer packetizer
package ctip_pkg;

   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_SENT  = 2'd1;
   localparam logic [1:0] MODE_SETUP = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] available_length;
      logic [7:0] host_length;
      logic       zero_length_end_allowed;
   } req_type;

   typedef struct packed {
      logic [3:0] packet_length;
      logic [7:0] buffer_offset;
      logic       data_toggle;
      logic       last;
   } rsp_type;

endpackage

// File: sv/control_in_transfer_packetizer_core.sv
// control in transfer packetizer: splits the in data stage into packets
// a request is registered, then its packet lands in the result register once the
// output register is free (not valid or not stalled)
// throughput: one request per cycle while the output is not stalled, set by the single state update step
// reset: synchronous, clears the transfer state and both valid registers
`include "assert_macros.svh"

module control_in_transfer_packetizer_core #(
   parameter int MAX_PACKET = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ctip_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ctip_pkg::rsp_type rsp_data
);

   localparam logic [7:0] PKT_BYTES = 8'(MAX_PACKET);
   localparam logic [3:0] FULL_LEN  = 4'(MAX_PACKET);

   logic              req_valid_ff;
   ctip_pkg::req_type req_data_ff;
   logic              rsp_valid_ff;
   ctip_pkg::rsp_type rsp_data_ff;
   ctip_pkg::rsp_type rsp_data_in;

   logic       transfer_active_ff, transfer_active_in;
   logic [7:0] bytes_remaining_ff, bytes_remaining_in;
   logic       end_empty_ff, end_empty_in;
   logic       toggle_ff, toggle_in;
   logic [7:0] next_offset_ff, next_offset_in;

   logic       out_free;
   logic       advance;
   logic       issue;
   logic       rsp_load;
   logic       is_start;
   logic       full_pkt;
   logic [7:0] cur_remaining;
   logic       cur_end_empty;
   logic       cur_toggle;
   logic [7:0] cur_offset;
   logic       mid_load;
   logic       end_load;
   logic       mid_out;
   logic       out_full;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = req_valid_ff && !out_free;
   assign advance   = req_valid_ff && out_free;
   assign rsp_load  = advance && issue;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign mid_load = rsp_load && !rsp_data_in.last;
   assign end_load = rsp_load && rsp_data_in.last;
   assign mid_out  = rsp_valid_ff && !rsp_data_ff.last;
   assign out_full = (rsp_data_ff.packet_length == FULL_LEN);

   always_comb begin
      is_start = (req_data_ff.mode == ctip_pkg::MODE_START);
      // a start loads fresh transfer state and issues the first packet at once
      if (is_start) begin
         if (req_data_ff.available_length >= req_data_ff.host_length) begin
            cur_remaining = req_data_ff.host_length;
            cur_end_empty = 1'b0;
         end else begin
            cur_remaining = req_data_ff.available_length;
            cur_end_empty = req_data_ff.zero_length_end_allowed;
         end
         cur_toggle = 1'b0;
         cur_offset = 8'd0;
      end else begin
         cur_remaining = bytes_remaining_ff;
         cur_end_empty = end_empty_ff;
         cur_toggle    = toggle_ff;
         cur_offset    = next_offset_ff;
      end

      issue = is_start ||
              ((req_data_ff.mode == ctip_pkg::MODE_SENT) && transfer_active_ff);
      // exactly one full packet left still needs a trailing empty packet
      full_pkt = (cur_remaining > PKT_BYTES) ||
                 ((cur_remaining == PKT_BYTES) && cur_end_empty);

      rsp_data_in.packet_length = full_pkt ? FULL_LEN : cur_remaining[3:0];
      rsp_data_in.buffer_offset = cur_offset;
      rsp_data_in.data_toggle   = !cur_toggle;
      rsp_data_in.last          = !full_pkt;

      transfer_active_in = transfer_active_ff;
      bytes_remaining_in = bytes_remaining_ff;
      end_empty_in       = end_empty_ff;
      toggle_in          = toggle_ff;
      next_offset_in     = next_offset_ff;

      if (issue) begin
         transfer_active_in = full_pkt;
         bytes_remaining_in = full_pkt ? (cur_remaining - PKT_BYTES) : 8'd0;
         end_empty_in       = full_pkt && cur_end_empty;
         toggle_in          = !cur_toggle;
         next_offset_in     = cur_offset + PKT_BYTES;
      end else if (req_data_ff.mode == ctip_pkg::MODE_SETUP) begin
         transfer_active_in = 1'b0;
         end_empty_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         req_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= rsp_load;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         transfer_active_ff <= 1'b0;
         bytes_remaining_ff <= 8'd0;
         end_empty_ff       <= 1'b0;
         toggle_ff          <= 1'b0;
         next_offset_ff     <= 8'd0;
      end else if (advance) begin
         transfer_active_ff <= transfer_active_in;
         bytes_remaining_ff <= bytes_remaining_in;
         end_empty_ff       <= end_empty_in;
         toggle_ff          <= toggle_in;
         next_offset_ff     <= next_offset_in;
      end
   end

   `ASSERT_NEXT(a_mid_active, clock, reset, mid_load, transfer_active_ff, "active dropped early")
   `ASSERT_NEXT(a_end_idle, clock, reset, end_load, !transfer_active_ff, "still active after last")
   `ASSERT_SAME(a_mid_full, clock, reset, mid_out, out_full, "short packet before the last")
   `ASSERT_SAME(a_flag_act, clock, reset, end_empty_ff, transfer_active_ff, "end flag while idle")

endmodule
